// ===== hdl/pixel_frame_to_page_byte_stream_assert.svh =====
// ----------------------------------------------------------------------------
// pixel_frame_to_page_byte_stream_assert
// assertion macros shared by the frame writer rtl
// ----------------------------------------------------------------------------
`ifndef PIXEL_FRAME_TO_PAGE_BYTE_STREAM_ASSERT_SVH
`define PIXEL_FRAME_TO_PAGE_BYTE_STREAM_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PFB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfb assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfb assertion failed");

`endif

// ===== hdl/pfb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfb_pkg
// constants and field widths of the page-mode frame writer
// ----------------------------------------------------------------------------
package pfb_pkg;

    localparam int FRAME_ROWS_DEF    = 32;
    localparam int FRAME_COLUMNS_DEF = 128;

    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int START_COL_W = 7;
    localparam int BYTE_W      = 8;

    localparam int CMD_BYTES = 4;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_STREAM = 1'b1;

    // position of each command byte within a page
    localparam int IDX_SET_PAGE = 0;
    localparam int IDX_PAGE_NUM = 1;
    localparam int IDX_COL_LOW  = 2;
    localparam int IDX_COL_HIGH = 3;

    localparam logic [BYTE_W-1:0] CMD_SET_PAGE = 8'h22;
    localparam logic [BYTE_W-1:0] CMD_HIGH_COL = 8'h10;

endpackage

// ===== hdl/pfb_channels.sv =====
// ----------------------------------------------------------------------------
// pfb_channels
// valid/ready channels of the frame writer: pixel items, stream bytes, config
// ----------------------------------------------------------------------------
interface pfb_item_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [pfb_pkg::ROW_W-1:0]       pixel_row;
    logic [pfb_pkg::COL_W-1:0]       pixel_column;
    logic                            pixel_on;

    modport source (output valid, mode, pixel_row, pixel_column, pixel_on, input ready);
    modport sink (input valid, mode, pixel_row, pixel_column, pixel_on, output ready);
endinterface

interface pfb_result_if;
    logic                            valid;
    logic                            ready;
    logic                            is_data;
    logic [pfb_pkg::BYTE_W-1:0]      stream_byte;
    logic                            frame_end;

    modport source (output valid, is_data, stream_byte, frame_end, input ready);
    modport sink (input valid, is_data, stream_byte, frame_end, output ready);
endinterface

interface pfb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pfb_pkg::START_COL_W-1:0] start_column;

    modport source (output valid, start_column, input ready);
    modport sink (input valid, start_column, output ready);
endinterface

// ===== hdl/pixel_frame_to_page_byte_stream.sv =====
// ----------------------------------------------------------------------------
// pixel_frame_to_page_byte_stream
// one-bit pixel frame in page layout, streamed out as display page commands
// and column data bytes
// ----------------------------------------------------------------------------
// Takes one beat per clock on pixel_in. A pixel write lands in the frame store
// at its acceptance edge and gives no beat out; a stream request's byte is
// loaded into the store read register at acceptance, then into the output
// register driving stream_out once that is empty or taken. Outside the reset
// sweep, pixel_in stalls only while both registers hold a beat and stream_out
// does not take one. The frame store is eight one-bit lanes, one per row
// within a page, so a pixel write is a plain single-bit write and a data byte
// is one read of all lanes. After reset the store is swept to zero one
// address per clock, over all 2**(page address bits + clog2(FRAME_COLUMNS))
// addresses, the page address being at least one bit wide (512 at the defaults);
// pixel_in is held not ready meanwhile, config writes are taken at any time.
`include "pixel_frame_to_page_byte_stream_assert.svh"

module pixel_frame_to_page_byte_stream #(
    parameter int FRAME_ROWS    = pfb_pkg::FRAME_ROWS_DEF,
    parameter int FRAME_COLUMNS = pfb_pkg::FRAME_COLUMNS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    pfb_item_if.sink          pixel_in,
    pfb_result_if.source      stream_out,
    pfb_cfg_if.sink           cfg
);

    localparam int PAGE_COUNT = (FRAME_ROWS + 7) / 8;
    localparam int PW         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CW         = $clog2(FRAME_COLUMNS);
    localparam int AW         = PW + CW;
    localparam int DEPTH      = 1 << AW;
    localparam int PAGE_LEN   = pfb_pkg::CMD_BYTES + FRAME_COLUMNS;
    localparam int IW         = $clog2(PAGE_LEN);
    localparam int BW         = pfb_pkg::BYTE_W;

    // control
    logic                           clearing_reg;
    logic [AW-1:0]                  clr_addr_reg;
    logic [pfb_pkg::START_COL_W-1:0] start_column_reg;
    logic [PW-1:0]                  stream_page_reg, stream_page_next;
    logic [IW-1:0]                  stream_index_reg, stream_index_next;
    logic                           a_vld_reg;
    logic                           out_vld_reg;

    // payload
    logic                           a_is_data_reg;
    logic [BW-1:0]                  a_cmd_reg;
    logic                           a_last_reg;
    logic                           rd_bit_reg [8];
    logic                           out_is_data_reg;
    logic [BW-1:0]                  out_byte_reg;
    logic                           out_last_reg;

    logic                           advance;
    logic                           in_accept;
    logic                           rd_en;
    logic                           wr_pixel;
    logic                           row_ok;
    logic                           col_ok;
    logic [PW+1:0]                  wr_page_ext;
    logic [AW-1:0]                  wr_addr;
    logic [AW-1:0]                  rd_addr;
    logic [IW-1:0]                  data_col;
    logic                           wr_bit;
    logic [2:0]                     wr_lane;
    logic                           cur_is_data;
    logic [BW-1:0]                  cur_cmd;
    logic                           cur_last;
    logic [BW-1:0]                  a_byte;

    assign advance         = !out_vld_reg || stream_out.ready;
    assign pixel_in.ready  = !clearing_reg && (!a_vld_reg || advance);
    assign in_accept       = pixel_in.valid && pixel_in.ready;
    assign rd_en           = in_accept && (pixel_in.mode == pfb_pkg::MODE_STREAM);
    assign cfg.ready       = 1'b1;

    // pixel write address
    assign row_ok      = int'(pixel_in.pixel_row) < FRAME_ROWS;
    assign col_ok      = int'(pixel_in.pixel_column) < FRAME_COLUMNS;
    assign wr_page_ext = (PW + 2)'(pixel_in.pixel_row[pfb_pkg::ROW_W-1:3]);
    assign wr_lane     = pixel_in.pixel_row[2:0];
    assign wr_pixel    = in_accept && (pixel_in.mode == pfb_pkg::MODE_WRITE)
                         && row_ok && col_ok;
    assign wr_addr     = clearing_reg ? clr_addr_reg
                         : {wr_page_ext[PW-1:0], pixel_in.pixel_column[CW-1:0]};
    assign wr_bit      = !clearing_reg && pixel_in.pixel_on;

    // stream position decode
    assign data_col = stream_index_reg - IW'(pfb_pkg::CMD_BYTES);
    assign rd_addr  = {stream_page_reg, data_col[CW-1:0]};

    always_comb
    begin
        cur_is_data = 1'b0;
        cur_cmd     = '0;
        unique case (stream_index_reg)
            IW'(pfb_pkg::IDX_SET_PAGE): cur_cmd = pfb_pkg::CMD_SET_PAGE;
            IW'(pfb_pkg::IDX_PAGE_NUM): cur_cmd = BW'(stream_page_reg);
            IW'(pfb_pkg::IDX_COL_LOW):  cur_cmd = {4'b0, start_column_reg[3:0]};
            IW'(pfb_pkg::IDX_COL_HIGH):
                cur_cmd = pfb_pkg::CMD_HIGH_COL | {5'b0, start_column_reg[6:4]};
            default:                    cur_is_data = 1'b1;
        endcase
    end

    always_comb
    begin
        stream_index_next = stream_index_reg + 1'b1;
        stream_page_next  = stream_page_reg;
        cur_last          = 1'b0;
        if (stream_index_reg == IW'(PAGE_LEN - 1))
        begin
            stream_index_next = '0;
            if (stream_page_reg == PW'(PAGE_COUNT - 1))
            begin
                stream_page_next = '0;
                cur_last         = 1'b1;
            end
            else
            begin
                stream_page_next = stream_page_reg + 1'b1;
            end
        end
    end

    // frame store, one bit lane per row within a page
    for (genvar k = 0; k < 8; k++)
    begin : g_lane
        logic lane_mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (clearing_reg || (wr_pixel && wr_lane == 3'(k)))
                lane_mem[wr_addr] <= wr_bit;
            if (rd_en)
                rd_bit_reg[k] <= lane_mem[rd_addr];
        end
    end

    always_comb
    begin
        a_byte = a_cmd_reg;
        if (a_is_data_reg)
        begin
            for (int k = 0; k < 8; k++)
                a_byte[k] = rd_bit_reg[k];
        end
    end

    // reset sweep, config and stream counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            start_column_reg <= '0;
            stream_page_reg  <= '0;
            stream_index_reg <= '0;
            a_vld_reg        <= 1'b0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == {AW{1'b1}})
                    clearing_reg <= 1'b0;
            end
            if (cfg.valid)
                start_column_reg <= cfg.start_column;
            if (rd_en)
            begin
                stream_page_reg  <= stream_page_next;
                stream_index_reg <= stream_index_next;
            end
            if (rd_en)
                a_vld_reg <= 1'b1;
            else if (advance)
                a_vld_reg <= 1'b0;
            if (advance)
                out_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            a_is_data_reg <= cur_is_data;
            a_cmd_reg     <= cur_cmd;
            a_last_reg    <= cur_last;
        end
        if (advance && a_vld_reg)
        begin
            out_is_data_reg <= a_is_data_reg;
            out_byte_reg    <= a_byte;
            out_last_reg    <= a_last_reg;
        end
    end

    assign stream_out.valid       = out_vld_reg;
    assign stream_out.is_data     = out_is_data_reg;
    assign stream_out.stream_byte = out_byte_reg;
    assign stream_out.frame_end   = out_last_reg;

    // checks
    `PFB_ASSERT_SAME(a_end_is_data, clk, rst_n, stream_out.valid && stream_out.frame_end, stream_out.is_data)
    `PFB_ASSERT_SAME(a_pos_in_range, clk, rst_n, 1'b1, (int'(stream_index_reg) < PAGE_LEN) && (int'(stream_page_reg) < PAGE_COUNT))
    `PFB_ASSERT_NEXT(a_sweep_full, clk, rst_n, clearing_reg && clr_addr_reg != {AW{1'b1}}, clearing_reg && !pixel_in.ready)

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// testbench for pixel_frame_to_page_byte_stream
// pixel writes and stream requests fed from a queue, a local frame copy
// predicts each stream beat, several start columns and idle patterns
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PAGES          = (pfb_pkg::FRAME_ROWS_DEF + 7) / 8;
    localparam int PAGE_LEN       = pfb_pkg::CMD_BYTES + pfb_pkg::FRAME_COLUMNS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 290;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        logic                        mode;
        logic [pfb_pkg::ROW_W-1:0]   row;
        logic [pfb_pkg::COL_W-1:0]   column;
        logic                        on;
    } pixel_request_t;

    typedef struct packed {
        logic                        is_data;
        logic [pfb_pkg::BYTE_W-1:0]  stream_byte;
        logic                        frame_end;
    } stream_beat_t;

    logic clk;
    logic rst_n;

    pfb_item_if   pixel_if ();
    pfb_result_if stream_if ();
    pfb_cfg_if    cfg_if ();

    pixel_frame_to_page_byte_stream dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pixel_if),
        .stream_out (stream_if),
        .cfg        (cfg_if)
    );

    pixel_request_t pixel_requests[$];
    stream_beat_t   predicted_beats[$];

    logic [pfb_pkg::BYTE_W-1:0]      frame_pages [PAGES][pfb_pkg::FRAME_COLUMNS_DEF]
                                     = '{default: '0};
    int                              page_ptr    = 0;
    int                              byte_ptr    = 0;
    logic [pfb_pkg::START_COL_W-1:0] col_setting = '0;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_cycles    = 0;
    int  idle_cycles    = 0;
    int  error_count    = 0;
    bit  request_taken  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic apply_pixel_request(input pixel_request_t req);
        stream_beat_t beat;
        beat = '0;
        if (req.mode == pfb_pkg::MODE_WRITE)
        begin
            if (req.row < pfb_pkg::FRAME_ROWS_DEF && req.column < pfb_pkg::FRAME_COLUMNS_DEF)
                frame_pages[req.row >> 3][req.column][req.row[2:0]] = req.on;
        end
        else
        begin
            if (page_ptr >= PAGES)
                page_ptr = 0;
            if (byte_ptr >= PAGE_LEN)
                byte_ptr = 0;
            case (byte_ptr)
                pfb_pkg::IDX_SET_PAGE: beat.stream_byte = pfb_pkg::CMD_SET_PAGE;
                pfb_pkg::IDX_PAGE_NUM: beat.stream_byte = pfb_pkg::BYTE_W'(page_ptr);
                pfb_pkg::IDX_COL_LOW:  beat.stream_byte = {4'h0, col_setting[3:0]};
                pfb_pkg::IDX_COL_HIGH:
                    beat.stream_byte = pfb_pkg::CMD_HIGH_COL | {5'b0, col_setting[6:4]};
                default:
                begin
                    beat.is_data     = 1'b1;
                    beat.stream_byte = frame_pages[page_ptr][byte_ptr - pfb_pkg::CMD_BYTES];
                end
            endcase
            byte_ptr++;
            if (byte_ptr >= PAGE_LEN)
            begin
                byte_ptr = 0;
                page_ptr++;
                if (page_ptr >= PAGES)
                begin
                    page_ptr        = 0;
                    beat.frame_end  = 1'b1;
                end
            end
            predicted_beats.push_back(beat);
        end
    endtask

    function automatic pixel_request_t make_request(input logic mode, input int row,
                                                    input int column, input logic on);
        pixel_request_t req;
        req.mode   = mode;
        req.row    = pfb_pkg::ROW_W'(row);
        req.column = pfb_pkg::COL_W'(column);
        req.on     = on;
        return req;
    endfunction

    function automatic pixel_request_t random_request();
        pixel_request_t req;
        req.mode   = ($urandom_range(99) < 65) ? pfb_pkg::MODE_STREAM : pfb_pkg::MODE_WRITE;
        req.row    = pfb_pkg::ROW_W'($urandom_range(pfb_pkg::FRAME_ROWS_DEF - 1));
        // half the writes land in a few columns so data bytes fill up
        req.column = pfb_pkg::COL_W'($urandom_range(1)
                                     ? $urandom_range(pfb_pkg::FRAME_COLUMNS_DEF - 1)
                                     : $urandom_range(7));
        req.on     = ($urandom_range(3) != 0);
        return req;
    endfunction

    // driver: offers the oldest pending request on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!pixel_if.valid || request_taken)
            begin
                request_taken = 1'b0;
                if (pixel_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pixel_if.valid        <= 1'b1;
                    pixel_if.mode         <= pixel_requests[0].mode;
                    pixel_if.pixel_row    <= pixel_requests[0].row;
                    pixel_if.pixel_column <= pixel_requests[0].column;
                    pixel_if.pixel_on     <= pixel_requests[0].on;
                end
                else
                    pixel_if.valid <= 1'b0;
            end
        end
    end

    // receiver ready, with an optional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            stream_if.ready <= 1'b0;
        else if (hold_cycles != 0)
        begin
            stream_if.ready <= 1'b0;
            hold_cycles--;
        end
        else
            stream_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predicts accepted requests and checks output beats
    always @(posedge clk)
    begin
        stream_beat_t want;
        bit           progress;
        progress = 1'b0;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                col_setting = cfg_if.start_column;
                progress    = 1'b1;
            end
            if (pixel_if.valid && pixel_if.ready)
            begin
                apply_pixel_request(pixel_requests.pop_front());
                request_taken = 1'b1;
                progress      = 1'b1;
            end
            if (stream_if.valid && stream_if.ready)
            begin
                progress = 1'b1;
                if (predicted_beats.size() == 0)
                begin
                    $error("unexpected beat: is_data %0d stream_byte 0x%02h frame_end %0d",
                           stream_if.is_data, stream_if.stream_byte, stream_if.frame_end);
                    error_count++;
                end
                else
                begin
                    want = predicted_beats.pop_front();
                    if (stream_if.is_data !== want.is_data)
                    begin
                        $error("is_data: expected %0d, actual %0d",
                               want.is_data, stream_if.is_data);
                        error_count++;
                    end
                    if (stream_if.stream_byte !== want.stream_byte)
                    begin
                        $error("stream_byte: expected 0x%02h, actual 0x%02h",
                               want.stream_byte, stream_if.stream_byte);
                        error_count++;
                    end
                    if (stream_if.frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0d, actual %0d",
                               want.frame_end, stream_if.frame_end);
                        error_count++;
                    end
                end
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic wait_until_drained();
        while (pixel_requests.size() != 0 || predicted_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_column(input logic [pfb_pkg::START_COL_W-1:0] value);
        @(negedge clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.start_column <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin
        int send_pcts [PHASES] = '{0, 79, 0, 25, 0, 40};
        int recv_pcts [PHASES] = '{0, 0, 79, 25, 0, 40};
        int col_values[PHASES] = '{127, 0, 64, 127, 85, 0};

        clk                   = 1'b0;
        rst_n                 = 1'b0;
        pixel_if.valid        = 1'b0;
        pixel_if.mode         = pfb_pkg::MODE_WRITE;
        pixel_if.pixel_row    = '0;
        pixel_if.pixel_column = '0;
        pixel_if.pixel_on     = 1'b0;
        stream_if.ready       = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.start_column   = '0;
        col_values[2]         = $urandom_range(1, 126);
        col_values[5]         = $urandom_range(1, 126);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_start_column('0);

        // corners, page edges, a pixel turned off, stream requests with stray fields and a write
        pixel_requests.push_back(make_request(pfb_pkg::MODE_WRITE, 0, 0, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_WRITE, 31, 127, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_WRITE, 7, 0, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_WRITE, 8, 0, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_WRITE, 0, 127, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_WRITE, 31, 0, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_WRITE, 3, 1, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_WRITE, 0, 0, 1'b0));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_WRITE, 15, 64, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_STREAM, 31, 127, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_STREAM, 0, 0, 1'b0));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_STREAM, 21, 42, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_STREAM, 10, 85, 1'b0));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_STREAM, 31, 127, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_STREAM, 0, 0, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_WRITE, 0, 0, 1'b1));
        pixel_requests.push_back(make_request(pfb_pkg::MODE_STREAM, 31, 127, 1'b0));
        wait_until_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            write_start_column(pfb_pkg::START_COL_W'(col_values[p]));
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
                pixel_requests.push_back(random_request());
            // long output stall while requests keep coming
            if (p == 4)
                hold_cycles = 300;
            wait_until_drained();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pfb_pkg.sv
hdl/pfb_channels.sv
hdl/pixel_frame_to_page_byte_stream.sv
tb/tb_top.sv
